// File: rtl/core/m2rgb_pkg.sv
// m2rgb_pkg: shared types, constants and the microcode program of the
// mired to rgb piecewise polynomial unit; used by every file in rtl/core
package m2rgb_pkg;

   localparam int TABLE_DEPTH = 32;
   localparam int IDX_W = $clog2(TABLE_DEPTH);
   localparam int MIRED_W = 26;
   localparam int VAL_W = 32;
   localparam int SHIFT_W = 6;
   localparam int PROD_W = VAL_W + MIRED_W + 1;
   localparam int SUM_W = PROD_W + 1;
   localparam int PROG_LEN = 48;
   localparam int PC_W = $clog2(PROG_LEN);
   localparam int CSR_IDX_W = 2;

   localparam logic signed [VAL_W-1:0] FULL_SCALE = VAL_W'(1 << 30);
   localparam logic [MIRED_W-1:0] MIRED_LOW_LIMIT = MIRED_W'(32'h42aaab - (1 << 6));
   localparam logic [MIRED_W:0] MIRED_HIGH_LIMIT = (MIRED_W + 1)'(32'h3e80000 + (1 << 6));

   localparam logic [CSR_IDX_W-1:0] CSR_RED_BREAK = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GREEN_BREAK = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_LOW_BREAK = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BLUE_HIGH_BREAK = 2'd3;

   localparam logic KIND_CONVERT = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   typedef struct packed {
      logic kind;
      logic [MIRED_W-1:0] mired;
      logic [4:0] entry_index;
      logic signed [VAL_W-1:0] coefficient;
      logic [SHIFT_W-1:0] step_shift;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] red;
      logic signed [VAL_W-1:0] green;
      logic signed [VAL_W-1:0] blue;
      logic range_error;
   } rsp_type;

   typedef struct packed {
      logic [MIRED_W-1:0] red_break;
      logic [MIRED_W-1:0] green_break;
      logic [MIRED_W-1:0] blue_low_break;
      logic [MIRED_W-1:0] blue_high_break;
   } cfg_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] coefficient;
      logic [SHIFT_W-1:0] step_shift;
   } entry_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LDACC,
      OP_MUL,
      OP_STEP,
      OP_FULL,
      OP_ZERO
   } op_type;

   typedef enum logic [1:0] {
      PUT_NONE,
      PUT_R,
      PUT_G,
      PUT_B
   } put_type;

   typedef enum logic [2:0] {
      J_NONE,
      J_ALWAYS,
      J_RED_FULL,
      J_GREEN_HIGH,
      J_BLUE_FULL,
      J_BLUE_ZERO
   } jcond_type;

   typedef struct packed {
      logic [IDX_W-1:0] addr;
      op_type op;
      put_type put;
      jcond_type jcond;
      logic [PC_W-1:0] target;
      logic last;
   } word_type;

   // datapath controls for one cycle
   typedef struct packed {
      logic [IDX_W-1:0] addr;
      op_type op;
      put_type put;
   } ctrl_type;

   function automatic word_type mk(input int addr, input op_type op, input put_type put,
                                   input jcond_type jcond, input int target, input logic last);
      word_type w;
      w.addr = IDX_W'(addr);
      w.op = op;
      w.put = put;
      w.jcond = jcond;
      w.target = PC_W'(target);
      w.last = last;
      return w;
   endfunction

   // table reads are registered and land in the next cycle, so each multiply
   // word fetches the coefficient that the following step word adds
   function automatic word_type rom_word(input int pc);
      word_type w;
      w = mk(0, OP_NOP, PUT_NONE, J_NONE, 0, 1'b0);
      case (pc)
         // red: order 4 at slots 3..0, else full
         0: w = mk(3, OP_NOP, PUT_NONE, J_RED_FULL, 8, 1'b0);
         1: w = mk(0, OP_LDACC, PUT_NONE, J_NONE, 0, 1'b0);
         2: w = mk(2, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         3: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         4: w = mk(1, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         5: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         6: w = mk(0, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         7: w = mk(0, OP_STEP, PUT_R, J_ALWAYS, 9, 1'b0);
         8: w = mk(0, OP_FULL, PUT_R, J_NONE, 0, 1'b0);
         // green low: order 4 at slots 7..4
         9: w = mk(7, OP_NOP, PUT_NONE, J_GREEN_HIGH, 17, 1'b0);
         10: w = mk(0, OP_LDACC, PUT_NONE, J_NONE, 0, 1'b0);
         11: w = mk(6, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         12: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         13: w = mk(5, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         14: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         15: w = mk(4, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         16: w = mk(0, OP_STEP, PUT_G, J_ALWAYS, 29, 1'b0);
         // green high: order 6 at slots 13..8
         17: w = mk(13, OP_NOP, PUT_NONE, J_NONE, 0, 1'b0);
         18: w = mk(0, OP_LDACC, PUT_NONE, J_NONE, 0, 1'b0);
         19: w = mk(12, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         20: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         21: w = mk(11, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         22: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         23: w = mk(10, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         24: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         25: w = mk(9, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         26: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         27: w = mk(8, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         28: w = mk(0, OP_STEP, PUT_G, J_NONE, 0, 1'b0);
         // blue: full, order 8 at slots 21..14, or zero
         29: w = mk(21, OP_NOP, PUT_NONE, J_BLUE_FULL, 45, 1'b0);
         30: w = mk(0, OP_LDACC, PUT_NONE, J_BLUE_ZERO, 46, 1'b0);
         31: w = mk(20, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         32: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         33: w = mk(19, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         34: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         35: w = mk(18, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         36: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         37: w = mk(17, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         38: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         39: w = mk(16, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         40: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         41: w = mk(15, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         42: w = mk(0, OP_STEP, PUT_NONE, J_NONE, 0, 1'b0);
         43: w = mk(14, OP_MUL, PUT_NONE, J_NONE, 0, 1'b0);
         44: w = mk(0, OP_STEP, PUT_B, J_ALWAYS, 47, 1'b0);
         45: w = mk(0, OP_FULL, PUT_B, J_ALWAYS, 47, 1'b0);
         46: w = mk(0, OP_ZERO, PUT_B, J_NONE, 0, 1'b0);
         47: w = mk(0, OP_NOP, PUT_NONE, J_NONE, 0, 1'b1);
         default: w = mk(0, OP_NOP, PUT_NONE, J_NONE, 0, 1'b1);
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/mired_to_rgb_piecewise_poly_unit.sv
// mired_to_rgb_piecewise_poly_unit: top level with request and result
// channels, break registers and range check; uses m2rgb_seq, m2rgb_dp, m2rgb_pkg
//
// Usage:
//  - req_*: a convert request (kind 0) gives one result on rsp_*; a load
//    request (kind 1) writes one coefficient table slot and gives no result.
//    A load to a slot at or past the table depth is dropped.
//  - csr_*: writes the four break registers, always ready; write them only
//    while no conversion is in flight.
//  - A load does not start the sequencer. A conversion runs a microcode
//    program on one shared multiplier, a multiply word and a step word per
//    horner step, so its length depends on the segments chosen: shortest
//    for red full, green low, blue full and longest for red poly, green high,
//    blue poly; req_stall stays high until it ends, so no new request is taken.
//  - The result sits in an output register: the next request is taken as
//    soon as the program ends, even while rsp_stall holds the last result.
//    If a second result is ready while the first is still stalled, the
//    program waits on its last step.
//  - Reset clears the break registers, the sequencer and rsp_valid; the
//    coefficient table is not cleared and must be loaded before use.
module mired_to_rgb_piecewise_poly_unit (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input m2rgb_pkg::req_type req_payload,
   output logic rsp_valid,
   input logic rsp_stall,
   output m2rgb_pkg::rsp_type rsp_payload,
   input logic csr_valid,
   output logic csr_ready,
   input logic [m2rgb_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [m2rgb_pkg::MIRED_W-1:0] csr_data
);

   m2rgb_pkg::cfg_type cfg_ff;
   logic [m2rgb_pkg::MIRED_W-1:0] mired_ff;
   logic err_ff;
   logic rsp_valid_ff, rsp_valid_in;
   m2rgb_pkg::rsp_type rsp_ff;

   logic req_fire, start, hold, done, busy, wr_en;
   logic [m2rgb_pkg::IDX_W-1:0] wr_addr;
   m2rgb_pkg::entry_type wr_data;
   m2rgb_pkg::ctrl_type ctrl;
   logic signed [m2rgb_pkg::VAL_W-1:0] red, green, blue;

   assign req_stall = busy;
   assign req_fire = req_valid && !req_stall;
   assign start = req_fire && (req_payload.kind == m2rgb_pkg::KIND_CONVERT);
   assign wr_en = req_fire && (req_payload.kind == m2rgb_pkg::KIND_LOAD)
                  && (32'(req_payload.entry_index) < 32'(m2rgb_pkg::TABLE_DEPTH));
   assign wr_addr = m2rgb_pkg::IDX_W'(req_payload.entry_index);
   assign wr_data.coefficient = req_payload.coefficient;
   assign wr_data.step_shift = req_payload.step_shift;

   assign hold = rsp_valid_ff && rsp_stall;
   assign rsp_valid_in = done || hold;
   assign csr_ready = 1'b1;

   m2rgb_seq u_seq (
      .clock(clock),
      .reset(reset),
      .start(start),
      .hold(hold),
      .mired(mired_ff),
      .cfg(cfg_ff),
      .ctrl(ctrl),
      .done(done),
      .busy(busy)
   );

   m2rgb_dp u_dp (
      .clock(clock),
      .ctrl(ctrl),
      .mired(mired_ff),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .red(red),
      .green(green),
      .blue(blue)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               m2rgb_pkg::CSR_RED_BREAK: cfg_ff.red_break <= csr_data;
               m2rgb_pkg::CSR_GREEN_BREAK: cfg_ff.green_break <= csr_data;
               m2rgb_pkg::CSR_BLUE_LOW_BREAK: cfg_ff.blue_low_break <= csr_data;
               m2rgb_pkg::CSR_BLUE_HIGH_BREAK: cfg_ff.blue_high_break <= csr_data;
               default: ;
            endcase
         end
      end
      if (start) begin
         mired_ff <= req_payload.mired;
         err_ff <= (req_payload.mired < m2rgb_pkg::MIRED_LOW_LIMIT)
                   || ({1'b0, req_payload.mired} >= m2rgb_pkg::MIRED_HIGH_LIMIT);
      end
      if (done) begin
         rsp_ff.red <= red;
         rsp_ff.green <= green;
         rsp_ff.blue <= blue;
         rsp_ff.range_error <= err_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

`ifndef ASSERT_OFF
   a_convert_starts_program: assert property (@(posedge clock) disable iff (reset)
      start |=> busy)
      else $error("convert request did not start the sequencer");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      done |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !busy)
      else $error("table load started the sequencer");
`endif

endmodule

// File: rtl/core/m2rgb_seq.sv
// m2rgb_seq: microcode sequencer, step counter, segment jumps and control word
// fetch from the program table; depends on m2rgb_pkg
module m2rgb_seq (
   input logic clock,
   input logic reset,
   input logic start,
   input logic hold,
   input logic [m2rgb_pkg::MIRED_W-1:0] mired,
   input m2rgb_pkg::cfg_type cfg,
   output m2rgb_pkg::ctrl_type ctrl,
   output logic done,
   output logic busy
);

   logic run_ff, run_in;
   logic [m2rgb_pkg::PC_W-1:0] pc_ff, pc_in;
   m2rgb_pkg::word_type word;
   logic taken;

   assign word = m2rgb_pkg::rom_word(int'(pc_ff));

   always_comb begin
      unique case (word.jcond)
         m2rgb_pkg::J_NONE: taken = 1'b0;
         m2rgb_pkg::J_ALWAYS: taken = 1'b1;
         m2rgb_pkg::J_RED_FULL: taken = mired >= cfg.red_break;
         m2rgb_pkg::J_GREEN_HIGH: taken = mired >= cfg.green_break;
         m2rgb_pkg::J_BLUE_FULL: taken = mired < cfg.blue_low_break;
         m2rgb_pkg::J_BLUE_ZERO: taken = mired >= cfg.blue_high_break;
         default: taken = 1'b0;
      endcase
   end

   // the last word waits there while the result register is still held
   assign done = run_ff && word.last && !hold;
   assign busy = run_ff;

   always_comb begin
      ctrl.addr = word.addr;
      ctrl.op = run_ff ? word.op : m2rgb_pkg::OP_NOP;
      ctrl.put = run_ff ? word.put : m2rgb_pkg::PUT_NONE;
   end

   always_comb begin
      run_in = run_ff;
      pc_in = pc_ff;
      if (start) begin
         run_in = 1'b1;
         pc_in = '0;
      end else if (run_ff) begin
         if (word.last) begin
            if (!hold) begin
               run_in = 1'b0;
            end
         end else if (taken) begin
            pc_in = word.target;
         end else begin
            pc_in = pc_ff + m2rgb_pkg::PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         pc_ff <= '0;
      end else begin
         run_ff <= run_in;
         pc_ff <= pc_in;
      end
   end

`ifndef ASSERT_OFF
   a_pc_in_program: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (pc_ff < m2rgb_pkg::PC_W'(m2rgb_pkg::PROG_LEN)))
      else $error("sequencer step counter left the program");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("conversion started while sequencer busy");
`endif

endmodule

// File: rtl/core/m2rgb_dp.sv
// m2rgb_dp: coefficient table, shared multiplier, horner accumulator and
// channel registers driven by the sequencer control word; depends on m2rgb_pkg
module m2rgb_dp (
   input logic clock,
   input m2rgb_pkg::ctrl_type ctrl,
   input logic [m2rgb_pkg::MIRED_W-1:0] mired,
   input logic wr_en,
   input logic [m2rgb_pkg::IDX_W-1:0] wr_addr,
   input m2rgb_pkg::entry_type wr_data,
   output logic signed [m2rgb_pkg::VAL_W-1:0] red,
   output logic signed [m2rgb_pkg::VAL_W-1:0] green,
   output logic signed [m2rgb_pkg::VAL_W-1:0] blue
);

   m2rgb_pkg::entry_type mem [m2rgb_pkg::TABLE_DEPTH];
   m2rgb_pkg::entry_type rd_ff;

   logic signed [m2rgb_pkg::VAL_W-1:0] acc_ff, acc_in;
   logic signed [m2rgb_pkg::PROD_W-1:0] prod_ff, prod_in;
   logic signed [m2rgb_pkg::SUM_W-1:0] sum, shifted;
   logic signed [m2rgb_pkg::MIRED_W:0] mired_s;
   logic signed [m2rgb_pkg::VAL_W-1:0] red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[ctrl.addr];
   end

   assign mired_s = $signed({1'b0, mired});
   assign prod_in = m2rgb_pkg::PROD_W'(acc_ff) * m2rgb_pkg::PROD_W'(mired_s);

   // product plus coefficient, arithmetic shift, keep the low word
   assign sum = m2rgb_pkg::SUM_W'(prod_ff) + m2rgb_pkg::SUM_W'(rd_ff.coefficient);
   assign shifted = sum >>> rd_ff.step_shift;

   always_comb begin
      case (ctrl.op)
         m2rgb_pkg::OP_LDACC: acc_in = rd_ff.coefficient;
         m2rgb_pkg::OP_STEP: acc_in = shifted[m2rgb_pkg::VAL_W-1:0];
         m2rgb_pkg::OP_FULL: acc_in = m2rgb_pkg::FULL_SCALE;
         m2rgb_pkg::OP_ZERO: acc_in = '0;
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.op == m2rgb_pkg::OP_MUL) begin
         prod_ff <= prod_in;
      end
      case (ctrl.put)
         m2rgb_pkg::PUT_R: red_ff <= acc_in;
         m2rgb_pkg::PUT_G: green_ff <= acc_in;
         m2rgb_pkg::PUT_B: blue_ff <= acc_in;
         default: ;
      endcase
   end

   assign red = red_ff;
   assign green = green_ff;
   assign blue = blue_ff;

endmodule

// File: sim/tb_top.sv
// tb_top: self-checking bench for mired_to_rgb_piecewise_poly_unit with a directed table,
// then random loads and conversions under several break settings
// depends on m2rgb_pkg and the unit's rtl, nothing else
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ONE_Q30 = 1 << 30;
   localparam int MIRED_FLOOR = 32'h42aaab - 64;
   localparam int MIRED_TOP = 32'h3e80000 + 64;
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 76;
   localparam int SETTLE = 8;
   localparam int TAIL = 64;

   typedef struct packed {
      m2rgb_pkg::req_type stim;
      logic typed;
      m2rgb_pkg::rsp_type want;
   } vector_type;

   // rows with typed set carry their answer; the rest go through the predictor
   localparam vector_type DIRECTED [23] = '{
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd13, 32'sd0, 6'd63}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd12, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd11, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd10, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd9, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd8, 32'sh7fffffff, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'd0, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b1}},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h3ffffff, 5'd31, 32'shffffffff, 6'd63}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b1}},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h42aa6a, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b1}},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h42aa6b, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b0}},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h3e8003f, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b0}},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h3e80040, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh7fffffff, 32'sd0, 1'b1}},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd8, 32'sh80000000, 6'd63}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h1000000, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'shffffffff, 32'sd0, 1'b0}},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd8, 32'sh80000000, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h2000000, 5'd0, 32'sd0, 6'd0}, 1'b1,
        '{32'sh40000000, 32'sh80000000, 32'sd0, 1'b0}},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd13, 32'sd1, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd12, 32'sh7fffffff, 6'd1}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h3ffffff, 5'd0, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h0000001, 5'd0, 32'sd0, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'h3ffffff, 5'd31, 32'sh55555555, 6'd42}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_LOAD, 26'd0, 5'd0, 32'shffffffff, 6'd0}, 1'b0, '0},
      '{'{m2rgb_pkg::KIND_CONVERT, 26'h2a2a2a2, 5'd0, 32'sd0, 6'd0}, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   m2rgb_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   m2rgb_pkg::rsp_type rsp_payload;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [m2rgb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [m2rgb_pkg::MIRED_W-1:0] csr_data = '0;

   // predictor state
   int coef_tbl [m2rgb_pkg::TABLE_DEPTH];
   logic [m2rgb_pkg::SHIFT_W-1:0] shift_tbl [m2rgb_pkg::TABLE_DEPTH];
   logic [m2rgb_pkg::MIRED_W-1:0] brk [4];
   m2rgb_pkg::rsp_type pending_colors [$];

   bit req_up = 1'b0;
   bit steady = 1'b0;
   int stall_left = 0;
   int error_count = 0;
   int n_converts = 0, n_loads = 0, n_out_of_range = 0, n_settings = 0, n_drains = 0;
   int n_red_poly = 0, n_red_full = 0, n_green_low = 0, n_green_high = 0;
   int n_blue_full = 0, n_blue_poly = 0, n_blue_zero = 0;

   mired_to_rgb_piecewise_poly_unit u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   initial begin
      #5_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   function automatic int pause_len();
      return steady ? 0 : int'($urandom_range(0, 7));
   endfunction

   // horner over slots base+order-1 down to base, truncating each step to 32 bits
   function automatic int eval_segment(input int base, input int order,
                                       input logic [m2rgb_pkg::MIRED_W-1:0] mired);
      int acc;
      longint m, sum;
      acc = coef_tbl[base + order - 1];
      m = {38'd0, mired};
      for (int k = order - 2; k >= 0; k--) begin
         sum = longint'(acc) * m + longint'(coef_tbl[base + k]);
         sum = sum >>> shift_tbl[base + k];
         acc = sum[31:0];
      end
      return acc;
   endfunction

   function automatic m2rgb_pkg::rsp_type color_of(input logic [m2rgb_pkg::MIRED_W-1:0] mired);
      m2rgb_pkg::rsp_type c;
      int mi;
      mi = {6'd0, mired};
      c.range_error = (mi < MIRED_FLOOR) || (mi >= MIRED_TOP);
      if (c.range_error) n_out_of_range++;
      if (mired < brk[m2rgb_pkg::CSR_RED_BREAK]) begin
         c.red = eval_segment(0, 4, mired);
         n_red_poly++;
      end else begin
         c.red = ONE_Q30;
         n_red_full++;
      end
      if (mired < brk[m2rgb_pkg::CSR_GREEN_BREAK]) begin
         c.green = eval_segment(4, 4, mired);
         n_green_low++;
      end else begin
         c.green = eval_segment(8, 6, mired);
         n_green_high++;
      end
      if (mired < brk[m2rgb_pkg::CSR_BLUE_LOW_BREAK]) begin
         c.blue = ONE_Q30;
         n_blue_full++;
      end else if (mired < brk[m2rgb_pkg::CSR_BLUE_HIGH_BREAK]) begin
         c.blue = eval_segment(14, 8, mired);
         n_blue_poly++;
      end else begin
         c.blue = '0;
         n_blue_zero++;
      end
      return c;
   endfunction

   function automatic m2rgb_pkg::req_type draw_request(input bit is_load, input int slot);
      m2rgb_pkg::req_type r;
      bit plain;
      r.kind = is_load ? m2rgb_pkg::KIND_LOAD : m2rgb_pkg::KIND_CONVERT;
      r.mired = m2rgb_pkg::MIRED_W'($urandom);
      r.entry_index = (slot >= 0) ? 5'(slot) : 5'($urandom);
      plain = $urandom_range(0, 1);
      // half the coefficients are modest fixed-point values with sane shifts
      r.coefficient = plain ? $urandom
                            : 32'(int'($urandom_range(0, 32'h200000)) - 32'h100000);
      r.step_shift = plain ? m2rgb_pkg::SHIFT_W'($urandom)
                           : m2rgb_pkg::SHIFT_W'($urandom_range(16, 30));
      if (!is_load) begin
         case ($urandom_range(0, 9))
            5: r.mired = m2rgb_pkg::MIRED_W'(
                  ($urandom_range(0, 1) ? MIRED_TOP : MIRED_FLOOR)
                  + int'($urandom_range(0, 4)) - 2);
            6, 7: r.mired = brk[$urandom_range(0, 3)]
                            + m2rgb_pkg::MIRED_W'($urandom_range(0, 4))
                            - m2rgb_pkg::MIRED_W'(2);
            8: ;
            9: r.mired = $urandom_range(0, 1) ? '1 : '0;
            default: r.mired = m2rgb_pkg::MIRED_W'($urandom_range(MIRED_FLOOR,
                                                                  MIRED_TOP - 1));
         endcase
      end
      return r;
   endfunction

   task automatic issue(input m2rgb_pkg::req_type r, input bit typed,
                        input m2rgb_pkg::rsp_type want);
      int gap;
      m2rgb_pkg::rsp_type guess;
      gap = pause_len();
      if (gap > 0) begin
         if (req_up) begin
            req_valid <= 1'b0;
            req_up = 1'b0;
         end
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      req_up = 1'b1;
      do @(posedge clock); while (req_stall);
      if (r.kind == m2rgb_pkg::KIND_LOAD) begin
         if (r.entry_index < m2rgb_pkg::TABLE_DEPTH) begin
            coef_tbl[r.entry_index] = r.coefficient;
            shift_tbl[r.entry_index] = r.step_shift;
         end
         n_loads++;
      end else begin
         guess = color_of(r.mired);
         pending_colors.push_back(typed ? want : guess);
         n_converts++;
      end
   endtask

   // hold requests back until every conversion has answered
   task automatic drain();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      do @(posedge clock); while (pending_colors.size() != 0);
   endtask

   task automatic program_breaks(input logic [m2rgb_pkg::MIRED_W-1:0] rb, gb, blb, bhb);
      logic [m2rgb_pkg::MIRED_W-1:0] v [4];
      v = '{rb, gb, blb, bhb};
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= m2rgb_pkg::CSR_IDX_W'(i);
         csr_data <= v[i];
         do @(posedge clock); while (!csr_ready);
         brk[i] = v[i];
      end
      csr_valid <= 1'b0;
      n_settings++;
   endtask

   // result side: check each accepted result, then stall the next one a while
   always @(posedge clock) begin
      m2rgb_pkg::rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_colors.size() == 0) begin
               $error("result with no conversion pending: %h", rsp_payload);
               error_count++;
            end else begin
               want = pending_colors.pop_front();
               if (rsp_payload.red !== want.red) begin
                  $error("red: expected %h, got %h", want.red, rsp_payload.red);
                  error_count++;
               end
               if (rsp_payload.green !== want.green) begin
                  $error("green: expected %h, got %h", want.green, rsp_payload.green);
                  error_count++;
               end
               if (rsp_payload.blue !== want.blue) begin
                  $error("blue: expected %h, got %h", want.blue, rsp_payload.blue);
                  error_count++;
               end
               if (rsp_payload.range_error !== want.range_error) begin
                  $error("range_error: expected %b, got %b", want.range_error,
                         rsp_payload.range_error);
                  error_count++;
               end
            end
            stall_left = pause_len();
            rsp_stall <= (stall_left != 0);
         end else if (rsp_valid && stall_left != 0) begin
            stall_left = stall_left - 1;
            if (stall_left == 0) rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      logic [m2rgb_pkg::MIRED_W-1:0] lo, hi, rb, gb;
      for (int i = 0; i < m2rgb_pkg::TABLE_DEPTH; i++) begin
         coef_tbl[i] = 0;
         shift_tbl[i] = '0;
      end
      for (int i = 0; i < 4; i++) brk[i] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // breaks still at reset, only the green high slots are used here
      foreach (DIRECTED[i]) issue(DIRECTED[i].stim, DIRECTED[i].typed, DIRECTED[i].want);

      // fill every slot a conversion can read before the breaks move
      for (int s = 0; s < 22; s++) issue(draw_request(1'b1, s), 1'b0, '0);

      for (int phase = 0; phase < PHASES; phase++) begin
         drain();
         repeat (SETTLE) @(posedge clock);
         case (phase)
            0: program_breaks('0, '0, '0, '0);
            1: program_breaks('1, '1, '1, '1);
            2: program_breaks(26'h1000000, 26'h1800000, 26'h0800000, 26'h2000000);
            3: program_breaks('1, '0, '0, '1);
            default: begin
               rb = m2rgb_pkg::MIRED_W'($urandom_range(MIRED_FLOOR - 32'h10000,
                                                       MIRED_TOP + 32'h10000));
               gb = m2rgb_pkg::MIRED_W'($urandom_range(MIRED_FLOOR - 32'h10000,
                                                       MIRED_TOP + 32'h10000));
               lo = m2rgb_pkg::MIRED_W'($urandom_range(MIRED_FLOOR - 32'h10000,
                                                       MIRED_TOP + 32'h10000));
               hi = m2rgb_pkg::MIRED_W'($urandom_range(MIRED_FLOOR - 32'h10000,
                                                       MIRED_TOP + 32'h10000));
               // last phase keeps the blue breaks in whatever order they came
               if (phase != PHASES - 1 && lo > hi) program_breaks(rb, gb, hi, lo);
               else program_breaks(rb, gb, lo, hi);
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 20 == 0) steady = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 40) == 0) begin
               drain();
               n_drains++;
            end
            issue(draw_request($urandom_range(0, 7) == 0, -1), 1'b0, '0);
         end
      end

      drain();
      repeat (TAIL) @(posedge clock);
      $display("covered %0d conversions (%0d out of range), %0d table loads,",
               n_converts, n_out_of_range, n_loads);
      $display("  %0d break settings, %0d full drains; segments: red poly/full %0d/%0d,",
               n_settings, n_drains, n_red_poly, n_red_full);
      $display("  green low/high %0d/%0d, blue full/poly/zero %0d/%0d/%0d",
               n_green_low, n_green_high, n_blue_full, n_blue_poly, n_blue_zero);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/m2rgb_pkg.sv
rtl/core/m2rgb_seq.sv
rtl/core/m2rgb_dp.sv
rtl/core/mired_to_rgb_piecewise_poly_unit.sv
sim/tb_top.sv
